// ===== rtl/afr_pkg.sv =====
`timescale 1ns / 1ps

package afr_pkg;

	// defaults for the top-level parameters
	localparam int FifoDepthDef = 64;

	// phase fraction width (ratio register is always Q4.16)
	localparam int PhaseFracBits = 16;
	localparam int RatioFracBits = 16;
	localparam int UpShift   = (PhaseFracBits >= RatioFracBits) ? PhaseFracBits - RatioFracBits : 0;
	localparam int DownShift = (PhaseFracBits < RatioFracBits) ? RatioFracBits - PhaseFracBits : 0;
	localparam int OutShift  = PhaseFracBits - 8;
	localparam int HalfShift = (PhaseFracBits > 8) ? PhaseFracBits - 9 : 0;

	// field widths
	localparam int SampleW = 12;
	localparam int OutW    = 20;
	localparam int RatioW  = 20;
	localparam int CntW    = 32;
	localparam int QuoW    = CntW + RatioFracBits;

	// reset values
	localparam logic [3:0]         NominalRst = 4'd5;
	localparam logic [3:0]         MaxPopRst  = 4'd8;
	localparam logic [19:0]        WindowRst  = 20'd65536;
	localparam logic [CntW-1:0]    Lookahead  = 32'd2;
	localparam logic [SampleW-1:0] MidScale   = 12'd2048;

	// function codes
	typedef enum logic [1:0] {
		FN_PUSH  = 2'd0,
		FN_TICK  = 2'd1,
		FN_PRIME = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_NOMINAL = 2'd0,
		REG_MAX_POP = 2'd1,
		REG_WINDOW  = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL,
		ST_DIV,
		ST_ADV,
		ST_OWE,
		ST_POP_A,
		ST_POP_D,
		ST_MUL,
		ST_FIN
	} state_t;

endpackage

// ===== rtl/afr_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module afr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [afr_pkg::QuoW-1:0]   dividend,
	input  logic [afr_pkg::CntW-1:0]   divisor,
	output logic                       done,
	output logic [afr_pkg::QuoW-1:0]   quotient
);
	import afr_pkg::*;

	localparam int CW = $clog2(QuoW);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [CntW-1:0] rem_q;
	logic [QuoW-1:0] quo_q;
	logic [CntW-1:0] div_q;
	logic [CntW:0]   trial;
	logic [CntW:0]   diff;
	logic            qbit;

	always_comb begin
		trial = {rem_q, quo_q[QuoW-1]};
		diff  = trial - {1'b0, div_q};
		qbit  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(QuoW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[CntW-1:0] : trial[CntW-1:0];
			quo_q <= {quo_q[QuoW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/adaptive_fractional_resampler_fifo.sv =====
`timescale 1ns / 1ps

// Channel  | handshake             | payload
// ---------+-----------------------+-------------------------------------------
// in       | in_valid / in_ready   | func, adc_sample
// out      | out_valid / out_ready | out_sample, sample_dropped, starved,
//          |                       | popped_count, fifo_level, ratio_calibrated,
//          |                       | current_ratio
// cfg      | cfg_we                | cfg_index, cfg_data
//
// One request at a time. Push, prime and no-op go from idle to finish. A tick
// runs calibration, the divide on a calibration tick (48-step divider), phase
// advance, the owed count, a read and a load per popped sample, the multiply and
// finish. Output sits in a register; the next request is taken while it waits,
// but its result is held back until the previous one has gone. Reset is
// asynchronous and clears all control state; FIFO storage is not cleared.
module adaptive_fractional_resampler_fifo #(
	parameter int FIFO_DEPTH = afr_pkg::FifoDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [11:0] adc_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [19:0] out_sample,
	output logic        sample_dropped,
	output logic        starved,
	output logic [3:0]  popped_count,
	output logic [5:0]  fifo_level,
	output logic        ratio_calibrated,
	output logic [19:0] current_ratio,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);
	import afr_pkg::*;

	localparam int AW     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int IncW   = RatioW + UpShift;
	localparam int SumW   = ((IncW > PhaseFracBits) ? IncW : PhaseFracBits) + 1;
	localparam int NumW   = SampleW + PhaseFracBits + 2;
	localparam int ProdW  = PhaseFracBits + SampleW + 2;
	localparam logic [AW-1:0] LastIdx = AW'(FIFO_DEPTH - 1);

	// configuration
	logic [3:0]  nominal_q, max_pop_q;
	logic [19:0] window_q;

	// state
	state_t                   state_q, state_d;
	logic [SampleW-1:0]       mem [FIFO_DEPTH];
	logic [SampleW-1:0]       rdata_q;
	logic [AW-1:0]            wr_idx_q, rd_idx_q;
	logic [RatioW-1:0]        ratio_q;
	logic                     calib_q;
	logic [CntW-1:0]          produced_q, ticks_q, win_prod_q, win_ticks_q;
	logic [CntW-1:0]          consumed_q, target_q;
	logic [PhaseFracBits-1:0] phase_q;
	logic [SampleW-1:0]       prev_q, curr_q;

	// per-request working registers
	logic                     dropped_q, starved_q, tick_q;
	logic [3:0]               popped_q, pop_left_q;
	logic [AW-1:0]            level_q;
	logic signed [ProdW-1:0]  prod_q;

	// output register
	logic        ovalid_q;
	logic [19:0] osample_q;
	logic        odrop_q, ostarve_q, ocal_q;
	logic [3:0]  opop_q;
	logic [5:0]  olevel_q;
	logic [19:0] oratio_q;

	// combinational
	logic [AW-1:0]       level, wr_next, rd_next;
	logic                accept, full;
	logic [CntW-1:0]     span;
	logic [CntW-1:0]     made;
	logic                div_start, div_done;
	logic [QuoW-1:0]     quot;
	logic                quot_ok;
	logic [IncW-1:0]     inc;
	logic [SumW-1:0]     psum;
	logic [CntW-1:0]     owed_raw;
	logic [3:0]          owed;
	logic signed [NumW-1:0] num;
	logic [NumW-1:0]     num_r;
	logic [AW+5:0]       level_wide;
	logic                out_free;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !ovalid_q || out_ready;

	always_comb begin
		level   = (wr_idx_q >= rd_idx_q) ? AW'(wr_idx_q - rd_idx_q)
		                                 : AW'(FIFO_DEPTH + int'(wr_idx_q) - int'(rd_idx_q));
		wr_next = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
		rd_next = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
		full    = (wr_next == rd_idx_q);
		span    = ticks_q - win_ticks_q;
		// samples produced since the window opened
		made    = produced_q - win_prod_q;
		quot_ok = (quot[QuoW-1:RatioW] == '0) && (quot[RatioW-1:RatioFracBits] != '0)
		          && (quot[RatioW-1:0] <= {max_pop_q, {RatioFracBits{1'b0}}});
		if (PhaseFracBits >= RatioFracBits)
			inc = IncW'({ratio_q, {UpShift{1'b0}}});
		else
			inc = IncW'(ratio_q >> DownShift);
		psum = SumW'(phase_q) + SumW'(inc);
		owed_raw = (target_q > consumed_q) ? target_q - consumed_q : '0;
		if (owed_raw > CntW'(max_pop_q))
			owed = max_pop_q;
		else
			owed = owed_raw[3:0];
		if (CntW'(owed) > CntW'(level_q))
			owed = 4'(level_q);
		// prev + phase*(curr-prev), round half up to Q12.8
		num   = $signed({2'b00, prev_q, {PhaseFracBits{1'b0}}}) + NumW'(prod_q);
		num_r = NumW'(num) + ((PhaseFracBits > 8) ? (NumW'(1) << HalfShift) : '0);
		level_wide = {6'd0, level_q};
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = (func_t'(func) == FN_TICK) ? ST_CAL : ST_FIN;
			end
			ST_CAL: begin
				if (span >= CntW'(window_q) && span != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_ADV;
			end
			ST_ADV:   state_d = ST_OWE;
			ST_OWE:   state_d = (owed != '0) ? ST_POP_A : ST_MUL;
			ST_POP_A: state_d = ST_POP_D;
			ST_POP_D: state_d = (pop_left_q > 4'd1) ? ST_POP_A : ST_MUL;
			ST_MUL:   state_d = ST_FIN;
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// divider captures made count and span on the start edge
	afr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({made, {RatioFracBits{1'b0}}}),
		.divisor  (span),
		.done     (div_done),
		.quotient (quot)
	);

	// configuration writes; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nominal_q <= NominalRst;
			max_pop_q <= MaxPopRst;
			window_q  <= WindowRst;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_NOMINAL: nominal_q <= cfg_data[3:0];
				REG_MAX_POP: max_pop_q <= cfg_data[3:0];
				REG_WINDOW:  window_q  <= cfg_data;
				default:     ;
			endcase
		end
	end

	// FIFO storage
	always_ff @(posedge clk) begin
		if (accept && func_t'(func) == FN_PUSH && !full)
			mem[wr_idx_q] <= adc_sample;
		if (state_q == ST_POP_A)
			rdata_q <= mem[rd_idx_q];
	end

	// datapath control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			ratio_q     <= RatioW'({NominalRst, {RatioFracBits{1'b0}}});
			calib_q     <= 1'b0;
			produced_q  <= '0;
			ticks_q     <= '0;
			win_prod_q  <= '0;
			win_ticks_q <= '0;
			consumed_q  <= '0;
			target_q    <= Lookahead;
			phase_q     <= '0;
			prev_q      <= MidScale;
			curr_q      <= MidScale;
			pop_left_q  <= '0;
			popped_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						popped_q <= '0;
						case (func_t'(func))
							FN_PUSH: begin
								produced_q <= produced_q + 1'b1;
								if (!full)
									wr_idx_q <= wr_next;
							end
							FN_TICK:  ticks_q <= ticks_q + 1'b1;
							FN_PRIME: begin
								win_prod_q  <= produced_q;
								win_ticks_q <= ticks_q;
							end
							default: ;
						endcase
					end
				end
				ST_CAL: begin
					// window restarts whether or not a divide follows
					if (span >= CntW'(window_q)) begin
						win_prod_q  <= produced_q;
						win_ticks_q <= ticks_q;
					end
				end
				ST_DIV: begin
					if (div_done && quot_ok) begin
						ratio_q <= quot[RatioW-1:0];
						calib_q <= 1'b1;
					end
				end
				ST_ADV: begin
					phase_q  <= psum[PhaseFracBits-1:0];
					target_q <= target_q + CntW'(psum[SumW-1:PhaseFracBits]);
				end
				ST_OWE: begin
					pop_left_q <= owed;
					popped_q   <= owed;
					consumed_q <= consumed_q + CntW'(owed);
				end
				ST_POP_A: rd_idx_q <= rd_next;
				ST_POP_D: begin
					prev_q     <= curr_q;
					curr_q     <= rdata_q;
					pop_left_q <= pop_left_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// per-request flags and the product
	always_ff @(posedge clk) begin
		if (accept) begin
			level_q   <= level;
			dropped_q <= (func_t'(func) == FN_PUSH) && full;
			starved_q <= (func_t'(func) == FN_TICK) && (CntW'(level) < CntW'(nominal_q));
		end
		if (state_q == ST_IDLE && accept)
			prod_q <= '0;
		else if (state_q == ST_MUL)
			prod_q <= ProdW'($signed({1'b0, phase_q})
			          * ($signed({1'b0, curr_q}) - $signed({1'b0, prev_q})));
	end

	// out_sample is only meaningful on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tick_q <= 1'b0;
		else if (accept)
			tick_q <= (func_t'(func) == FN_TICK);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			osample_q <= tick_q ? num_r[OutShift +: OutW] : '0;
			odrop_q   <= dropped_q;
			ostarve_q <= starved_q;
			opop_q    <= popped_q;
			olevel_q  <= level_wide[5:0];
			ocal_q    <= calib_q;
			oratio_q  <= ratio_q;
		end
	end

	assign out_valid        = ovalid_q;
	assign out_sample       = osample_q;
	assign sample_dropped   = odrop_q;
	assign starved          = ostarve_q;
	assign popped_count     = opop_q;
	assign fifo_level       = olevel_q;
	assign ratio_calibrated = ocal_q;
	assign current_ratio    = oratio_q;

endmodule
